### design/bdrgb_pkg.sv
// shared types and constants of the box downscaler
package bdrgb_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_FACTOR = 16;

   // fixed field widths
   localparam int PIX_W      = 8;
   localparam int SCALE_W    = 5;
   localparam int SWIDTH_W   = 12;
   localparam int HEIGHT_W   = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   // derived widths
   localparam int FACT_W  = $clog2(MAX_FACTOR + 1);
   localparam int PH_W    = $clog2(MAX_FACTOR);
   localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int AREA_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
   localparam int RSUM_W  = $clog2(MAX_FACTOR * 255 + 1);
   localparam int CSUM_W  = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
   localparam int DIV_W   = CSUM_W + 1;
   localparam int STEP_W  = $clog2(PIX_W);
   localparam int POS_LIM = (MAX_WIDTH > (1 << HEIGHT_W)) ? MAX_WIDTH : (1 << HEIGHT_W);
   localparam int POS_W   = $clog2(POS_LIM + MAX_FACTOR + 1);

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

   // reset values
   localparam logic [FACT_W-1:0]   RST_FACTOR = FACT_W'(2);
   localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(480);
   localparam logic [AREA_W-1:0]   RST_AREA   = AREA_W'(4);

   // channel 0 red, 1 green, 2 blue
   typedef logic [2:0][PIX_W-1:0]  pix3_type;
   typedef logic [2:0][RSUM_W-1:0] rsum3_type;
   typedef logic [2:0][CSUM_W-1:0] csum3_type;

   // one finished horizontal run of a square
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             first;
      logic             last;
      logic             frame_end;
      rsum3_type        sum;
   } cmd_type;

endpackage

### design/bdrgb_ram.sv
// generic single write port ram with registered read
module bdrgb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bdrgb_cmd_fifo.sv
// short queue of run commands between front and back
module bdrgb_cmd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bdrgb_pkg::cmd_type  push_data,
   output logic                full,
   input  logic                pop,
   output bdrgb_pkg::cmd_type  pop_data,
   output logic                empty
);

   localparam int DEPTH = bdrgb_pkg::CMDQ_DEPTH;
   localparam int PTR_W = bdrgb_pkg::CMDQ_PTR_W;

   bdrgb_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/bdrgb_front.sv
// front end: registers, frame position and horizontal run sums
module bdrgb_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [bdrgb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bdrgb_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                  accept,
   input  bdrgb_pkg::pix3_type                   pixel,
   output logic                                  cmd_push,
   output bdrgb_pkg::cmd_type                    cmd_data,
   output logic [bdrgb_pkg::AREA_W-1:0]          area
);

   localparam int FACT_W   = bdrgb_pkg::FACT_W;
   localparam int WIDTH_W  = bdrgb_pkg::WIDTH_W;
   localparam int HEIGHT_W = bdrgb_pkg::HEIGHT_W;
   localparam int COL_W    = bdrgb_pkg::COL_W;
   localparam int PH_W     = bdrgb_pkg::PH_W;
   localparam int POS_W    = bdrgb_pkg::POS_W;
   localparam int AREA_W   = bdrgb_pkg::AREA_W;
   localparam int RSUM_W   = bdrgb_pkg::RSUM_W;

   logic [FACT_W-1:0]   scale_ff, scale_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [AREA_W-1:0]   area_ff, area_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [PH_W-1:0]     pa_ff, pa_in;
   logic [PH_W-1:0]     pd_ff, pd_in;
   logic [COL_W-1:0]    ocol_ff, ocol_in;
   bdrgb_pkg::rsum3_type rsum_ff, rsum_in, rsum_add;

   logic [POS_W-1:0] f_p, w_p, h_p, col_p1, row_p1;
   logic row_kept, col_kept, sq_done, band_done, last_col, last_row, kept;
   logic restart;
   logic [bdrgb_pkg::SCALE_W-1:0]  raw_f;
   logic [bdrgb_pkg::SWIDTH_W-1:0] raw_w;
   logic [HEIGHT_W-1:0]            raw_h;
   logic [FACT_W-1:0]              new_f;

   assign f_p    = POS_W'(scale_ff);
   assign w_p    = POS_W'(width_ff);
   assign h_p    = POS_W'(height_ff);
   assign col_p1 = POS_W'(col_ff) + 1'b1;
   assign row_p1 = POS_W'(row_ff) + 1'b1;

   // a square or band is taken only if it fits whole in the frame
   assign row_kept  = (pd_ff != '0) || (POS_W'(row_ff) + f_p <= h_p);
   assign col_kept  = (pa_ff != '0) || (POS_W'(col_ff) + f_p <= w_p);
   assign kept      = row_kept && col_kept;
   assign sq_done   = (POS_W'(pa_ff) + 1'b1 >= f_p);
   assign band_done = (POS_W'(pd_ff) + 1'b1 >= f_p);
   assign last_col  = (col_p1 + f_p > w_p);
   assign last_row  = (row_p1 + f_p > h_p);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rsum_add[c] = rsum_ff[c] + RSUM_W'(pixel[c]);
      end
   end

   assign cmd_push           = accept && kept && sq_done;
   assign cmd_data.col       = ocol_ff;
   assign cmd_data.first     = (pd_ff == '0);
   assign cmd_data.last      = band_done;
   assign cmd_data.frame_end = band_done && last_row && last_col;
   assign cmd_data.sum       = rsum_add;
   assign area               = area_ff;

   assign raw_f = csr_write_data[bdrgb_pkg::SCALE_W-1:0];
   assign raw_w = csr_write_data[bdrgb_pkg::SWIDTH_W-1:0];
   assign raw_h = csr_write_data[HEIGHT_W-1:0];

   always_comb begin
      if (raw_f == '0) begin
         new_f = FACT_W'(1);
      end else if (32'(raw_f) > bdrgb_pkg::MAX_FACTOR) begin
         new_f = FACT_W'(bdrgb_pkg::MAX_FACTOR);
      end else begin
         new_f = FACT_W'(raw_f);
      end
   end

   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      area_in   = area_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pa_in     = pa_ff;
      pd_in     = pd_ff;
      ocol_in   = ocol_ff;
      rsum_in   = rsum_ff;
      restart   = 1'b0;

      if (accept) begin
         if (kept) begin
            if (sq_done) begin
               rsum_in = '0;
               ocol_in = ocol_ff + 1'b1;
               pa_in   = '0;
            end else begin
               rsum_in = rsum_add;
               pa_in   = pa_ff + 1'b1;
            end
         end
         col_in = col_ff + 1'b1;
         if (col_p1 >= w_p) begin
            col_in  = '0;
            ocol_in = '0;
            pa_in   = '0;
            rsum_in = '0;
            if (row_kept) begin
               pd_in = band_done ? '0 : pd_ff + 1'b1;
            end
            row_in = row_ff + 1'b1;
            if (row_p1 >= h_p) begin
               row_in = '0;
               pd_in  = '0;
            end
         end
      end

      if (csr_write_enable) begin
         case (csr_index)
            bdrgb_pkg::REG_SCALE_FACTOR: begin
               scale_in = new_f;
               area_in  = AREA_W'({{FACT_W{1'b0}}, new_f} * {{FACT_W{1'b0}}, new_f});
               restart  = 1'b1;
            end
            bdrgb_pkg::REG_SOURCE_WIDTH: begin
               if (raw_w == '0) begin
                  width_in = WIDTH_W'(1);
               end else if (32'(raw_w) > bdrgb_pkg::MAX_WIDTH) begin
                  width_in = WIDTH_W'(bdrgb_pkg::MAX_WIDTH);
               end else begin
                  width_in = WIDTH_W'(raw_w);
               end
               restart = 1'b1;
            end
            bdrgb_pkg::REG_SOURCE_HEIGHT: begin
               height_in = (raw_h == '0) ? HEIGHT_W'(1) : raw_h;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end

      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         pa_in   = '0;
         pd_in   = '0;
         ocol_in = '0;
         rsum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= bdrgb_pkg::RST_FACTOR;
         width_ff  <= bdrgb_pkg::RST_WIDTH;
         height_ff <= bdrgb_pkg::RST_HEIGHT;
         area_ff   <= bdrgb_pkg::RST_AREA;
         col_ff    <= '0;
         row_ff    <= '0;
         pa_ff     <= '0;
         pd_ff     <= '0;
         ocol_ff   <= '0;
         rsum_ff   <= '0;
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         area_ff   <= area_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pa_ff     <= pa_in;
         pd_ff     <= pd_in;
         ocol_ff   <= ocol_in;
         rsum_ff   <= rsum_in;
      end
   end

endmodule

### design/bdrgb_back.sv
// back end: column store update, division by the area and result register
module bdrgb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_empty,
   input  bdrgb_pkg::cmd_type              cmd_data,
   output logic                            cmd_pop,
   input  logic [bdrgb_pkg::AREA_W-1:0]    area,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [bdrgb_pkg::PIX_W-1:0]     rsp_red_out,
   output logic [bdrgb_pkg::PIX_W-1:0]     rsp_green_out,
   output logic [bdrgb_pkg::PIX_W-1:0]     rsp_blue_out,
   output logic                            rsp_frame_end
);

   localparam int CSUM_W = bdrgb_pkg::CSUM_W;
   localparam int DIV_W  = bdrgb_pkg::DIV_W;
   localparam int PIX_W  = bdrgb_pkg::PIX_W;
   localparam int STEP_W = bdrgb_pkg::STEP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff;
   bdrgb_pkg::cmd_type   cmd_ff;
   bdrgb_pkg::csum3_type rem_ff;
   logic [2:0][PIX_W-1:0] quot_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 valid_ff;
   logic [PIX_W-1:0]     red_ff, green_ff, blue_ff;
   logic                 fend_ff;

   bdrgb_pkg::csum3_type ram_rdata, acc_sum;
   logic                 ram_we, ram_re;
   logic                 rsp_load;
   logic [DIV_W-1:0]     divisor;
   logic [2:0][DIV_W-1:0] trial;

   assign ram_re   = (state_ff == ST_IDLE) && !cmd_empty;
   assign cmd_pop  = ram_re;
   assign ram_we   = (state_ff == ST_ACC);
   assign rsp_load = (state_ff == ST_DONE) && (!valid_ff || rsp_pop);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc_sum[c] = cmd_ff.first ? CSUM_W'(cmd_ff.sum[c])
                                   : ram_rdata[c] + CSUM_W'(cmd_ff.sum[c]);
      end
   end

   // restoring division, one quotient bit per cycle, msb first
   assign divisor = DIV_W'(area) << step_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         trial[c] = {1'b0, rem_ff[c]} - divisor;
      end
   end

   bdrgb_ram #(
      .WIDTH(3 * CSUM_W),
      .DEPTH(bdrgb_pkg::MAX_WIDTH)
   ) u_col_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(cmd_ff.col),
      .wr_data(acc_sum),
      .rd_en  (ram_re),
      .rd_addr(cmd_data.col),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            valid_ff <= 1'b1;
         end else if (rsp_pop && valid_ff) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff   <= cmd_data;
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (cmd_ff.last) begin
                  rem_ff   <= acc_sum;
                  quot_ff  <= '0;
                  step_ff  <= STEP_W'(PIX_W - 1);
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  if (!trial[c][DIV_W-1]) begin
                     rem_ff[c] <= trial[c][CSUM_W-1:0];
                  end
                  quot_ff[c] <= {quot_ff[c][PIX_W-2:0], !trial[c][DIV_W-1]};
               end
               if (step_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  red_ff   <= quot_ff[0];
                  green_ff <= quot_ff[1];
                  blue_ff  <= quot_ff[2];
                  fend_ff  <= cmd_ff.frame_end;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_frame_end = fend_ff;

endmodule

### design/box_downscale_rgb_unit.sv
// top level of the rgb box filter downscaler
// Box filter downscaler for a raster-order RGB pixel stream: every
// scale_factor x scale_factor square becomes one pixel holding the truncated
// channel means, partial columns and rows at the right and bottom edges are
// dropped, and the last pixel of the small frame carries rsp_frame_end.
// Writing any register restarts the frame position. The front end takes one
// pixel per clock whenever its four-entry command queue has room; the back
// end handles one queued run at a time: every finished horizontal run of a
// square passes through a line store read, then accumulate and write, and a
// run that completes an output pixel then also goes through the 8-step
// divider and the result load, which waits while the last result is unread.
// The line store has no clearing pass after reset.
module box_downscale_rgb_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [bdrgb_pkg::PIX_W-1:0]         req_red_in,
   input  logic [bdrgb_pkg::PIX_W-1:0]         req_green_in,
   input  logic [bdrgb_pkg::PIX_W-1:0]         req_blue_in,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [bdrgb_pkg::PIX_W-1:0]         rsp_red_out,
   output logic [bdrgb_pkg::PIX_W-1:0]         rsp_green_out,
   output logic [bdrgb_pkg::PIX_W-1:0]         rsp_blue_out,
   output logic                                rsp_frame_end,
   input  logic                                csr_write_enable,
   input  logic [bdrgb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdrgb_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic                          accept;
   logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
   bdrgb_pkg::cmd_type            cmd_in, cmd_out;
   bdrgb_pkg::pix3_type           pixel;
   logic [bdrgb_pkg::AREA_W-1:0]  area;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign pixel    = {req_blue_in, req_green_in, req_red_in};

   bdrgb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .accept          (accept),
      .pixel           (pixel),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_in),
      .area            (area)
   );

   bdrgb_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_in),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_data (cmd_out),
      .empty    (cmd_empty)
   );

   bdrgb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_empty),
      .cmd_data     (cmd_out),
      .cmd_pop      (cmd_pop),
      .area         (area),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_red_out  (rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out (rsp_blue_out),
      .rsp_frame_end(rsp_frame_end)
   );

`ifndef SYNTH
   // the front only emits a run when the queue could take it
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("run command pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("back end popped an empty queue");

   // end of frame can only come with a run that completes an output pixel
   a_frame_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd_in.frame_end) |-> cmd_in.last)
      else $error("frame end marked on a run that finishes no square");
`endif

endmodule
